[hdl/imra_pkg.sv]
// Shared constants, types and status codes for the interval map range assign block.
package imra_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int VAL_W = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int ST_W  = 2;

    localparam logic [ST_W-1:0] ST_APPLIED  = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECTED = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } entry_t;

    typedef struct packed {
        logic scan_load;
        logic scan_shift;
        logic commit;
    } cell_ctrl_t;

endpackage

[hdl/interval_map_range_assign_core.sv]
// Top level: interval map range assign with a scan chain of table cells.
// Flow: a non-empty range passes a load step, a scan/insert walk of the chain and a commit
// step, an empty one none of them; each then takes a report load step before the first
// result, and results follow one per cycle while m_tready is high. No new item is taken
// until the report run ends, as the scan chain walks the table once to rebuild it and once more to report it.
// Reset: rst_n clears the control state, entry_count and base_value; the table is empty.
module interval_map_range_assign_core
    import imra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // range_begin[31:0], range_end[63:32], new_value[71:64]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[1:0], entry_key[33:2], entry_value[41:34],
                                   // entry_valid[42], zero pad[47:43]
    output logic        m_tlast
);

    localparam logic [2:0] ADDR_BASE = 3'd0;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_COMMIT, S_RLOAD, S_REPORT} state_t;
    // which part of the rebuilt list the scan is producing
    typedef enum logic [1:0] {P_LOW, P_MID, P_HIGH} phase_t;

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;

    logic [VAL_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] count_reg, count_next;   // committed entry count
    logic [CNT_W-1:0] rem_reg, rem_next;       // entries left in the scan chain
    logic [CNT_W-1:0] m_reg, m_next;           // entries written to the staging row
    logic             ovf_reg, ovf_next;
    logic [VAL_W-1:0] endv_reg, endv_next;     // value in force at range_end
    logic [VAL_W-1:0] prev_reg, prev_next;     // merge: predecessor value
    logic [ST_W-1:0]  status_reg, status_next;
    logic signed [KEY_W-1:0] beg_reg, beg_next, end_reg, end_next;
    logic [VAL_W-1:0] val_reg, val_next;

    logic             ov_reg, ov_next;
    logic [47:0]      od_reg, od_next;
    logic             ol_reg, ol_next;

    cell_ctrl_t ctrl;
    entry_t     scan_ent [DEPTH];
    logic       emit, keep, full;
    entry_t     emit_ent, head;
    logic       have;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_BASE) ? {{(32-VAL_W){1'b0}}, base_reg} : 32'd0;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

    assign head = scan_ent[0];
    assign have = (rem_reg != '0);
    assign full = (m_reg == CNT_W'(DEPTH));
    assign keep = emit && (emit_ent.value != prev_reg);

    // row of cells; the scan stage hands its entry to the left neighbor on each shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t right;
        logic   we;
        if (i == DEPTH - 1)
        begin : g_tail
            assign right = scan_ent[i];
        end
        else
        begin : g_mid
            assign right = scan_ent[i+1];
        end
        assign we = keep && !full && (m_reg[IDX_W-1:0] == IDX_W'(i));
        imra_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .scan_in (right),
            .wr_en   (we),
            .wr_data (emit_ent),
            .scan    (scan_ent[i])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        ph_next     = ph_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        m_next      = m_reg;
        ovf_next    = ovf_reg;
        endv_next   = endv_reg;
        prev_next   = prev_reg;
        status_next = status_reg;
        beg_next    = beg_reg;
        end_next    = end_reg;
        val_next    = val_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        ol_next     = ol_reg;
        ctrl        = '0;
        emit        = 1'b0;
        emit_ent    = head;

        if (psel && penable && pwrite && (paddr == ADDR_BASE))
        begin
            base_next = pwdata[VAL_W-1:0];
        end

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    beg_next = s_tdata[31:0];
                    end_next = s_tdata[63:32];
                    val_next = s_tdata[71:64];
                    if ($signed(s_tdata[31:0]) < $signed(s_tdata[63:32]))
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_RLOAD;
                    end
                end
            end
            S_LOAD:
            begin
                ctrl.scan_load = 1'b1;
                rem_next   = count_reg;
                m_next     = '0;
                ovf_next   = 1'b0;
                endv_next  = base_reg;
                prev_next  = base_reg;
                ph_next    = P_LOW;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                case (ph_reg)
                    P_LOW:
                    begin
                        if (have && (head.key < beg_reg))
                        begin
                            emit = 1'b1;
                            ctrl.scan_shift = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                            emit_ent.key   = beg_reg;
                            emit_ent.value = val_reg;
                            ph_next = P_MID;
                        end
                    end
                    P_MID:
                    begin
                        if (have && (head.key <= end_reg))
                        begin
                            ctrl.scan_shift = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                            emit_ent.key   = end_reg;
                            emit_ent.value = endv_reg;
                            ph_next = P_HIGH;
                        end
                    end
                    P_HIGH:
                    begin
                        if (have)
                        begin
                            emit = 1'b1;
                            ctrl.scan_shift = 1'b1;
                        end
                        else
                        begin
                            state_next = S_COMMIT;
                        end
                    end
                    default:
                    begin
                        ph_next = P_LOW;
                    end
                endcase
                if (ctrl.scan_shift)
                begin
                    rem_next = rem_reg - CNT_W'(1);
                    if (head.key <= end_reg)
                    begin
                        endv_next = head.value;
                    end
                end
                if (emit)
                begin
                    prev_next = emit_ent.value;
                end
                if (keep)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        m_next = m_reg + CNT_W'(1);
                    end
                end
            end
            S_COMMIT:
            begin
                if (ovf_reg)
                begin
                    status_next = ST_REJECTED;
                end
                else
                begin
                    ctrl.commit = 1'b1;
                    count_next  = m_reg;
                    status_next = ST_APPLIED;
                end
                state_next = S_RLOAD;
            end
            S_RLOAD:
            begin
                ctrl.scan_load = 1'b1;
                rem_next   = count_reg;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    ol_next = (rem_reg <= CNT_W'(1));
                    if (have)
                    begin
                        od_next = {5'd0, 1'b1, head.value, head.key, status_reg};
                        ctrl.scan_shift = 1'b1;
                        rem_next = rem_reg - CNT_W'(1);
                    end
                    else
                    begin
                        od_next = {5'd0, 1'b0, {VAL_W{1'b0}}, {KEY_W{1'b0}}, status_reg};
                    end
                    if (rem_reg <= CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ph_reg     <= P_LOW;
            base_reg   <= '0;
            count_reg  <= '0;
            rem_reg    <= '0;
            m_reg      <= '0;
            ovf_reg    <= 1'b0;
            status_reg <= ST_APPLIED;
            ov_reg     <= 1'b0;
            ol_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ph_reg     <= ph_next;
            base_reg   <= base_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            m_reg      <= m_next;
            ovf_reg    <= ovf_next;
            status_reg <= status_next;
            ov_reg     <= ov_next;
            ol_reg     <= ol_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        endv_reg <= endv_next;
        prev_reg <= prev_next;
        beg_reg  <= beg_next;
        end_reg  <= end_next;
        val_reg  <= val_next;
        od_reg   <= od_next;
    end

endmodule

[hdl/imra_cell.sv]
// One table cell: committed entry, scan stage and staging entry for the rebuilt table.
module imra_cell
    import imra_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     scan_in,
    input  logic       wr_en,
    input  entry_t     wr_data,
    output entry_t     scan
);

    entry_t tbl_reg, tbl_next;
    entry_t scan_reg, scan_next;
    entry_t stage_reg, stage_next;

    always_comb
    begin
        tbl_next   = ctrl.commit ? stage_reg : tbl_reg;
        stage_next = wr_en ? wr_data : stage_reg;
        scan_next  = scan_reg;
        if (ctrl.scan_load)
        begin
            scan_next = tbl_reg;
        end
        else if (ctrl.scan_shift)
        begin
            scan_next = scan_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg   <= tbl_next;
        scan_reg  <= scan_next;
        stage_reg <= stage_next;
    end

    assign scan = scan_reg;

endmodule

[hdl/imra_checker.sv]
// Port-level checker for the interval map range assign block, bound to the top level.
module imra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // no new item while a report run is unfinished
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready during report run");

    // an empty-table result is the only result of its run
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[42] |-> m_tlast)
        else $error("empty report not marked last");

    // after a transfer in, the block is busy
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken back to back");

    // status code is never the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad status code");

endmodule

bind interval_map_range_assign_core imra_checker u_imra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
